// ===== rtl/core/sprite_animation_sequencer_defines.svh =====
// Assertion macros shared by the sprite animation sequencer RTL.
`ifndef SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`define SPRITE_ANIMATION_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define SAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// Check that cons holds in the cycle after ante.
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`else
`define SAS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/sas_pkg.sv =====
// Types, widths and codes shared by the sprite animation sequencer modules.
package sas_pkg;

    // Action set and its index width
    localparam int NUM_ACTIONS = 8;
    localparam int ACT_W       = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
    localparam logic [ACT_W-1:0] ACT_LAST = ACT_W'(NUM_ACTIONS - 1);

    // Field widths
    localparam int KIND_W   = 2;
    localparam int DELTA_W  = 16;
    localparam int COUNT_W  = 10;
    localparam int PERIOD_W = 16;
    localparam int ACTO_W   = 3;

    // Divider: dividend covers the time total or frame + steps, divisor covers the period or frame count
    localparam int DVD_W = 18;
    localparam int DVS_W = 16;
    localparam int CNT_W = $clog2(DVD_W);

    // Event codes
    localparam logic [KIND_W-1:0] KIND_NEXT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PREV  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic apply_evt;
        logic div_step;
        logic take_rem1;
        logic take_rem2;
        logic out_load;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;
        logic quot_zero;
    } t_status;

    // Result payload
    typedef struct packed {
        logic               animating;
        logic               frame_changed;
        logic [COUNT_W-1:0] frame_now;
        logic               paused_now;
        logic               builder_shown;
        logic [ACTO_W-1:0]  action_now;
    } t_out;

endpackage

// ===== rtl/core/sprite_animation_sequencer.sv =====
// Next, previous, pause and non-advancing ticks give a result without the divider; a tick that divides
// by the period runs it once, and one that also advances the frame runs it again for the frame count.
// A new transaction is accepted only in idle, after the previous result is loaded, as the shared 18-step
// radix-2 divider runs once for the period and once for the frame count.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (synchronous, active low) selects action 0, builder page off, unpaused, frame 0, no leftover.
module sprite_animation_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // delta_time[15:0], frames_in_clip[25:16],
                                       // frame_period[41:26], zero fill
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // action_now[2:0], builder_shown[3], paused_now[4],
                                       // frame_now[14:5], frame_changed[15], animating[16],
                                       // zero fill
);
    import sas_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    t_out    w_result;

    sas_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    sas_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_kind           (s_axis_tuser),
        .i_delta_time     (s_axis_tdata[15:0]),
        .i_frames_in_clip (s_axis_tdata[25:16]),
        .i_frame_period   (s_axis_tdata[41:26]),
        .o_status         (w_status),
        .o_result         (w_result)
    );

    // Pack the result transaction
    assign m_axis_tdata = {7'b0, w_result.animating, w_result.frame_changed,
                           w_result.frame_now, w_result.paused_now,
                           w_result.builder_shown, w_result.action_now};

endmodule

// ===== rtl/core/sas_divider.sv =====
// Radix-2 restoring divider, one quotient bit per step.
`include "sprite_animation_sequencer_defines.svh"
module sas_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic                      i_step,
    input  logic [sas_pkg::DVD_W-1:0] i_dividend,
    input  logic [sas_pkg::DVS_W-1:0] i_divisor,
    output logic [sas_pkg::DVD_W-1:0] o_quot,
    output logic [sas_pkg::DVS_W-1:0] o_rem
);
    import sas_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Load operands, then shift quotient bits into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
        end
    end

    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

    `SAS_ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, i_step, r_dvs != '0)
    `SAS_ASSERT_SAME(a_div_excl, i_clk, i_rst_n, i_load, !i_step)
    `SAS_ASSERT_NEXT(a_rem_below, i_clk, i_rst_n, i_step, r_rem < r_dvs)

endmodule

// ===== rtl/core/sas_ctrl.sv =====
// Sequencing state machine and output valid for the animation sequencer.
`include "sprite_animation_sequencer_defines.svh"
module sas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    input  sas_pkg::t_status  i_status,
    output sas_pkg::t_cmd     o_cmd
);
    import sas_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_DIV1   = 3'd2;
    localparam logic [2:0] S_CHK    = 3'd3;
    localparam logic [2:0] S_DIV2   = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    t_cmd             w_cmd;

    // Next state, step count and command decode
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_m_ready;
        w_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                w_cmd.apply_evt = 1'b1;
                n_cnt           = '0;
                n_state         = i_status.need_div ? S_DIV1 : S_RESULT;
            end
            S_DIV1: begin
                w_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                w_cmd.take_rem1 = 1'b1;
                n_cnt           = '0;
                n_state         = i_status.quot_zero ? S_RESULT : S_DIV2;
            end
            S_DIV2: begin
                w_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                w_cmd.take_rem2 = 1'b1;
                n_state         = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || i_m_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;
    assign o_cmd     = w_cmd;

    `SAS_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, w_cmd.capture, r_state == S_EVAL)
    `SAS_ASSERT_SAME(a_load_free, i_clk, i_rst_n, w_cmd.out_load, !r_out_valid || i_m_ready)
    `SAS_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, w_cmd.div_step, r_cnt <= CNT_LAST)

endmodule

// ===== rtl/core/sas_datapath.sv =====
// Sequencer state, event update, shared divider and result register.
`include "sprite_animation_sequencer_defines.svh"
module sas_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sas_pkg::t_cmd                i_cmd,
    input  logic [sas_pkg::KIND_W-1:0]   i_kind,
    input  logic [sas_pkg::DELTA_W-1:0]  i_delta_time,
    input  logic [sas_pkg::COUNT_W-1:0]  i_frames_in_clip,
    input  logic [sas_pkg::PERIOD_W-1:0] i_frame_period,
    output sas_pkg::t_status             o_status,
    output sas_pkg::t_out                o_result
);
    import sas_pkg::*;

    // Captured item
    logic [KIND_W-1:0]   r_kind;
    logic [DELTA_W-1:0]  r_delta;
    logic [COUNT_W-1:0]  r_count;
    logic [PERIOD_W-1:0] r_period;

    // Playback state
    logic [ACT_W-1:0]    r_action;
    logic                r_builder;
    logic                r_paused;
    logic [COUNT_W-1:0]  r_frame;
    logic [DVS_W-1:0]    r_leftover;
    logic                r_changed;
    t_out                r_out;

    logic                w_clear;
    logic [DVS_W:0]      w_total;
    logic                w_div_load;
    logic [DVD_W-1:0]    w_dividend;
    logic [DVS_W-1:0]    w_divisor;
    logic [DVD_W-1:0]    w_quot;
    logic [DVS_W-1:0]    w_rem;
    logic [ACT_W+2:0]    w_act_ext;

    // Timing reset condition of a tick
    assign w_clear = r_builder || (r_count <= COUNT_W'(1)) || (r_period == '0);
    assign w_total = {1'b0, r_leftover} + {1'b0, r_delta};

    assign o_status.need_div  = (r_kind == KIND_TICK) && !w_clear && !r_paused;
    assign o_status.quot_zero = (w_quot == '0);

    // First division: total by period; second: frame + steps by frame count
    assign w_div_load = i_cmd.apply_evt | i_cmd.take_rem1;
    assign w_dividend = i_cmd.take_rem1 ? ({{(DVD_W-COUNT_W){1'b0}}, r_frame} + w_quot)
                                        : {{(DVD_W-DVS_W-1){1'b0}}, w_total};
    assign w_divisor  = i_cmd.take_rem1 ? {{(DVS_W-COUNT_W){1'b0}}, r_count} : r_period;

    sas_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_delta  <= i_delta_time;
            r_count  <= i_frames_in_clip;
            r_period <= i_frame_period;
        end
    end

    // Apply the event and commit division results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action   <= '0;
            r_builder  <= 1'b0;
            r_paused   <= 1'b0;
            r_frame    <= '0;
            r_leftover <= '0;
            r_changed  <= 1'b0;
        end else if (i_cmd.apply_evt) begin
            r_changed <= 1'b0;
            case (r_kind)
                KIND_NEXT: begin
                    if (r_builder) begin
                        r_builder <= 1'b0;
                        r_action  <= '0;
                    end else if (r_action >= ACT_LAST) begin
                        r_builder <= 1'b1;
                    end else begin
                        r_action <= r_action + 1'b1;
                    end
                    r_frame    <= '0;
                    r_leftover <= '0;
                end
                KIND_PREV: begin
                    if (r_builder) begin
                        r_builder <= 1'b0;
                        r_action  <= ACT_LAST;
                    end else if (r_action == '0) begin
                        r_builder <= 1'b1;
                    end else begin
                        r_action <= r_action - 1'b1;
                    end
                    r_frame    <= '0;
                    r_leftover <= '0;
                end
                KIND_PAUSE: begin
                    if (!r_builder) begin
                        r_paused <= ~r_paused;
                    end
                end
                KIND_TICK: begin
                    if (w_clear) begin
                        r_frame    <= '0;
                        r_leftover <= '0;
                    end
                end
                default: begin
                    r_changed <= 1'b0;
                end
            endcase
        end else if (i_cmd.take_rem1) begin
            r_leftover <= w_rem;
            r_changed  <= (w_quot != '0);
        end else if (i_cmd.take_rem2) begin
            r_frame <= w_rem[COUNT_W-1:0];
        end
    end

    // Result register
    assign w_act_ext = {3'b000, r_action};

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.action_now    <= w_act_ext[ACTO_W-1:0];
            r_out.builder_shown <= r_builder;
            r_out.paused_now    <= r_paused;
            r_out.frame_now     <= r_frame;
            r_out.frame_changed <= r_changed;
            r_out.animating     <= !r_builder && !r_paused && (r_count > COUNT_W'(1));
        end
    end

    assign o_result = r_out;

    `SAS_ASSERT_NEXT(a_leftover_fits, i_clk, i_rst_n, i_cmd.take_rem1, r_leftover < r_period)
    `SAS_ASSERT_NEXT(a_frame_fits, i_clk, i_rst_n, i_cmd.take_rem2, r_frame < r_count)
    `SAS_ASSERT_SAME(a_pause_builder, i_clk, i_rst_n, i_cmd.apply_evt && r_builder,
                     !o_status.need_div)

endmodule
